@@ rtl/core/erm_pkg.sv @@
// Shared types, constants and fixed-point helpers for the Euler rotation matrix block.
// Depends on nothing; every other file in rtl/core except erm_queue uses it.
package erm_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;

   // Internal sines and cosines are Q1.30
   localparam logic [30:0] P_ONE   = 31'd1073741824;
   localparam logic [29:0] PI4_Q30 = 30'd843314857;
   localparam logic [29:0] OCT_SPAN = 30'd536870912;

   localparam int N_TERMS   = 6;
   localparam int SC_LAT    = 2 + 3 * N_TERMS + 2;
   localparam int BK_LAT    = SC_LAT + 4;
   localparam int MIDQ_DEPTH = 4;
   localparam int OUTQ_DEPTH = 32;

   localparam int LANE_SIN = 0;
   localparam int LANE_COS = 1;

   // Horner divisors, sine lane then cosine lane
   localparam logic [7:0] DIV_TAB [2][N_TERMS] = '{
      '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6},
      '{8'd132, 8'd90,  8'd56, 8'd30, 8'd12, 8'd2}
   };

   // floor(2^32 / divisor)
   localparam logic [31:0] RECIP_TAB [2][N_TERMS] = '{
      '{32'((33'd1 << 32) / 33'd156), 32'((33'd1 << 32) / 33'd110),
        32'((33'd1 << 32) / 33'd72),  32'((33'd1 << 32) / 33'd42),
        32'((33'd1 << 32) / 33'd20),  32'((33'd1 << 32) / 33'd6)},
      '{32'((33'd1 << 32) / 33'd132), 32'((33'd1 << 32) / 33'd90),
        32'((33'd1 << 32) / 33'd56),  32'((33'd1 << 32) / 33'd30),
        32'((33'd1 << 32) / 33'd12),  32'((33'd1 << 32) / 33'd2)}
   };

   // One angle after classification: octant and folded residue
   typedef struct packed {
      logic [2:0]  oct;
      logic [29:0] res;
   } class_type;

   typedef class_type [2:0] class_word_type;

   // Signed Q1.30 product, rounded half away from zero
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic        neg;
      logic [30:0] ua;
      logic [30:0] ub;
      logic [61:0] prod;
      logic [31:0] mag;
      neg  = a[31] ^ b[31];
      ua   = a[31] ? 31'(-a) : 31'(a);
      ub   = b[31] ? 31'(-b) : 31'(b);
      prod = (62'(ua) * 62'(ub) + (62'd1 << 29)) >> 30;
      mag  = 32'(prod);
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

@@ rtl/core/euler_rotation_matrix.sv @@
// Euler angle (x, y, z) to 3x3 rotation matrix, transposed Rz*Ry*Rx layout, Q2.14 entries.
// Depends on erm_pkg, erm_front, erm_queue, erm_back.
//
// Push one angle triple per cycle. The fully pipelined back end takes one word a cycle
// while output queue credit lasts, so the sustained rate is one matrix per clock as long
// as results are popped. Each word waits in the input queue, then passes the Taylor
// sine/cosine pipeline (six Horner terms) and matrix stages A to D on its way to the outputs.
// A 32-word output queue absorbs pop stalls; full rises only when all output queue slots
// are held or reserved for words in flight and the 4-word input queue is full.
module euler_rotation_matrix #(
   parameter int ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF,
   parameter int FRAC_BITS  = erm_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [ANGLE_BITS-1:0]       req_angle_x,
   input  logic [ANGLE_BITS-1:0]       req_angle_y,
   input  logic [ANGLE_BITS-1:0]       req_angle_z,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic signed [FRAC_BITS+1:0] rsp_m00,
   output logic signed [FRAC_BITS+1:0] rsp_m01,
   output logic signed [FRAC_BITS+1:0] rsp_m02,
   output logic signed [FRAC_BITS+1:0] rsp_m10,
   output logic signed [FRAC_BITS+1:0] rsp_m11,
   output logic signed [FRAC_BITS+1:0] rsp_m12,
   output logic signed [FRAC_BITS+1:0] rsp_m20,
   output logic signed [FRAC_BITS+1:0] rsp_m21,
   output logic signed [FRAC_BITS+1:0] rsp_m22
);
   localparam int CW = $bits(erm_pkg::class_word_type);

   erm_pkg::class_word_type cls_front, cls_back;
   logic                    midq_empty, midq_pop;
   logic [$clog2(erm_pkg::MIDQ_DEPTH):0] midq_count;
   logic [8:0][FRAC_BITS+1:0] m;

   erm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .angle_x (req_angle_x),
      .angle_y (req_angle_y),
      .angle_z (req_angle_z),
      .cls     (cls_front)
   );

   erm_queue #(
      .WIDTH (CW),
      .DEPTH (erm_pkg::MIDQ_DEPTH)
   ) u_midq (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cls_front),
      .full  (req_full),
      .pop   (midq_pop),
      .rdata (cls_back),
      .empty (midq_empty),
      .count (midq_count)
   );

   erm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cls       (cls_back),
      .cls_empty (midq_empty),
      .cls_pop   (midq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_m     (m)
   );

   logic unused_count;
   assign unused_count = ^midq_count;

   assign rsp_m00 = m[0];
   assign rsp_m01 = m[1];
   assign rsp_m02 = m[2];
   assign rsp_m10 = m[3];
   assign rsp_m11 = m[4];
   assign rsp_m12 = m[5];
   assign rsp_m20 = m[6];
   assign rsp_m21 = m[7];
   assign rsp_m22 = m[8];
endmodule

@@ rtl/core/erm_queue.sv @@
// Small first-in first-out queue on a register array.
// Depends on nothing but its parameters.
module erm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       empty,
   output logic [$clog2(DEPTH):0]     count
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end
endmodule

@@ rtl/core/erm_front.sv @@
// Front end: splits each angle into an octant and a folded residue.
// Depends on erm_pkg.
module erm_front #(
   parameter int ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF
) (
   input  logic [ANGLE_BITS-1:0]   angle_x,
   input  logic [ANGLE_BITS-1:0]   angle_y,
   input  logic [ANGLE_BITS-1:0]   angle_z,
   output erm_pkg::class_word_type cls
);
   logic [31:0] turn [3];

   always_comb begin
      turn[0] = 32'(angle_x) << (32 - ANGLE_BITS);
      turn[1] = 32'(angle_y) << (32 - ANGLE_BITS);
      turn[2] = 32'(angle_z) << (32 - ANGLE_BITS);
      for (int i = 0; i < 3; i++) begin
         cls[i].oct = turn[i][31:29];
         // fold odd octants so the residue runs toward the octant start
         cls[i].res = turn[i][29] ? erm_pkg::OCT_SPAN - 30'(turn[i][28:0])
                                  : 30'(turn[i][28:0]);
      end
   end
endmodule

@@ rtl/core/erm_poly_step.sv @@
// One Horner term for the sine and cosine lanes: multiply, reciprocal divide, correct.
// Depends on erm_pkg.
module erm_poly_step #(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic [29:0] x2,
   input  logic [30:0] p_in [2],
   output logic [30:0] p_out [2]
);
   logic [29:0] q_ff  [2];
   logic [29:0] qt_ff [2];
   logic [29:0] qc_ff [2];
   logic [30:0] p_ff  [2];
   logic [30:0] rem   [2];
   logic [29:0] quot  [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rem[l]  = 31'(qc_ff[l]) - 31'(38'(qt_ff[l]) * 38'(erm_pkg::DIV_TAB[l][STEP]));
         quot[l] = (rem[l] >= 31'(erm_pkg::DIV_TAB[l][STEP])) ? qt_ff[l] + 1'b1 : qt_ff[l];
         p_out[l] = p_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         q_ff[l]  <= 30'((61'(x2) * 61'(p_in[l])) >> 30);
         qt_ff[l] <= 30'((62'(q_ff[l]) * 62'(erm_pkg::RECIP_TAB[l][STEP])) >> 32);
         qc_ff[l] <= q_ff[l];
         p_ff[l]  <= erm_pkg::P_ONE - 31'(quot[l]);
      end
   end
endmodule

@@ rtl/core/erm_sincos.sv @@
// Pipelined Q1.30 sine and cosine of one classified angle.
// Depends on erm_pkg and erm_poly_step.
module erm_sincos (
   input  logic               clock,
   input  erm_pkg::class_type cls,
   output logic signed [31:0] sin_q,
   output logic signed [31:0] cos_q
);
   localparam int NT = erm_pkg::N_TERMS;

   logic [29:0] x_d  [3*NT+2];
   logic [29:0] x2_d [3*NT-2];
   logic [2:0]  oct_d [3*NT+3];
   logic [30:0] p_chain [NT+1][2];
   logic [29:0] s_ff;
   logic [30:0] c_ff;
   logic signed [31:0] sin_ff, cos_ff;
   logic signed [31:0] s_sg, c_sg;

   assign p_chain[0][0] = erm_pkg::P_ONE;
   assign p_chain[0][1] = erm_pkg::P_ONE;

   for (genvar j = 0; j < NT; j++) begin : g_step
      erm_poly_step #(.STEP(j)) u_step (
         .clock (clock),
         .x2    (x2_d[3*j]),
         .p_in  (p_chain[j]),
         .p_out (p_chain[j+1])
      );
   end

   always_ff @(posedge clock) begin
      x_d[0]   <= 30'((60'(cls.res) * 60'(erm_pkg::PI4_Q30) + (60'd1 << 28)) >> 29);
      oct_d[0] <= cls.oct;
      for (int k = 1; k < 3*NT+2; k++) begin
         x_d[k] <= x_d[k-1];
      end
      for (int k = 1; k < 3*NT+3; k++) begin
         oct_d[k] <= oct_d[k-1];
      end
      x2_d[0] <= 30'((60'(x_d[0]) * 60'(x_d[0])) >> 30);
      for (int k = 1; k < 3*NT-2; k++) begin
         x2_d[k] <= x2_d[k-1];
      end
      s_ff <= 30'((61'(x_d[3*NT+1]) * 61'(p_chain[NT][erm_pkg::LANE_SIN])) >> 30);
      c_ff <= p_chain[NT][erm_pkg::LANE_COS];
      sin_ff <= s_sg;
      cos_ff <= c_sg;
   end

   // Unfold by octant symmetry
   always_comb begin
      case (oct_d[3*NT+2])
         3'd0: begin s_sg = 32'(s_ff);  c_sg = 32'(c_ff);  end
         3'd1: begin s_sg = 32'(c_ff);  c_sg = 32'(s_ff);  end
         3'd2: begin s_sg = 32'(c_ff);  c_sg = -32'(s_ff); end
         3'd3: begin s_sg = 32'(s_ff);  c_sg = -32'(c_ff); end
         3'd4: begin s_sg = -32'(s_ff); c_sg = -32'(c_ff); end
         3'd5: begin s_sg = -32'(c_ff); c_sg = -32'(s_ff); end
         3'd6: begin s_sg = -32'(c_ff); c_sg = 32'(s_ff);  end
         default: begin s_sg = -32'(s_ff); c_sg = 32'(c_ff); end
      endcase
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;
endmodule

@@ rtl/core/erm_back.sv @@
// Back end: issues classified words into the sine/cosine and matrix pipeline,
// holds finished words in an output queue. Depends on erm_pkg, erm_sincos, erm_queue.
module erm_back #(
   parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  erm_pkg::class_word_type            cls,
   input  logic                               cls_empty,
   output logic                               cls_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [8:0][FRAC_BITS+1:0]          rsp_m
);
   localparam int OUT_W = FRAC_BITS + 2;
   localparam int SH    = 30 - FRAC_BITS;
   localparam logic [33:0] RND = 34'((64'd1 << SH) >> 1);
   localparam logic [33:0] SAT = 34'd1 << FRAC_BITS;
   localparam int OQ_AW = $clog2(erm_pkg::OUTQ_DEPTH);
   localparam int LAT   = erm_pkg::BK_LAT;

   logic signed [31:0] sn [3];
   logic signed [31:0] cs [3];
   logic [LAT-1:0]     vld_ff;
   logic [OQ_AW:0]     inflight_ff, inflight_in;
   logic [OQ_AW:0]     oq_count;
   logic               oq_full;
   logic               oq_push;

   // stage A
   logic signed [31:0] sxsy_ff, cxsy_ff, cycz_ff, cysz_ff, sxcy_ff, cxcy_ff;
   logic signed [31:0] cxsz_ff, cxcz_ff, sxsz_ff, sxcz_ff, sy_ff, cz_ff, sz_ff;
   // stage B
   logic signed [31:0] t10_ff, t11_ff, t20_ff, t21_ff;
   logic signed [31:0] b_cycz_ff, b_cysz_ff, b_sxcy_ff, b_cxcy_ff, b_sy_ff;
   logic signed [31:0] b_cxsz_ff, b_cxcz_ff, b_sxsz_ff, b_sxcz_ff;
   // stage C
   logic signed [33:0] v_ff [9];
   // stage D
   logic [8:0][OUT_W-1:0] m_ff;
   logic [8:0][OUT_W-1:0] m_in;

   // issue only with a guaranteed slot in the output queue
   assign cls_pop = !cls_empty &&
                    ((OQ_AW+2)'(oq_count) + (OQ_AW+2)'(inflight_ff) <
                     (OQ_AW+2)'(erm_pkg::OUTQ_DEPTH));
   assign oq_push = vld_ff[LAT-1];

   always_comb begin
      inflight_in = inflight_ff + (OQ_AW+1)'(cls_pop) - (OQ_AW+1)'(oq_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         inflight_ff <= '0;
      end else begin
         vld_ff      <= {vld_ff[LAT-2:0], cls_pop};
         inflight_ff <= inflight_in;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_sc
      erm_sincos u_sc (
         .clock (clock),
         .cls   (cls[i]),
         .sin_q (sn[i]),
         .cos_q (cs[i])
      );
   end

   always_ff @(posedge clock) begin
      sxsy_ff <= erm_pkg::mul_q30(sn[0], sn[1]);
      cxsy_ff <= erm_pkg::mul_q30(cs[0], sn[1]);
      cycz_ff <= erm_pkg::mul_q30(cs[1], cs[2]);
      cysz_ff <= erm_pkg::mul_q30(cs[1], sn[2]);
      sxcy_ff <= erm_pkg::mul_q30(sn[0], cs[1]);
      cxcy_ff <= erm_pkg::mul_q30(cs[0], cs[1]);
      cxsz_ff <= erm_pkg::mul_q30(cs[0], sn[2]);
      cxcz_ff <= erm_pkg::mul_q30(cs[0], cs[2]);
      sxsz_ff <= erm_pkg::mul_q30(sn[0], sn[2]);
      sxcz_ff <= erm_pkg::mul_q30(sn[0], cs[2]);
      sy_ff   <= sn[1];
      cz_ff   <= cs[2];
      sz_ff   <= sn[2];

      t10_ff    <= erm_pkg::mul_q30(sxsy_ff, cz_ff);
      t11_ff    <= erm_pkg::mul_q30(sxsy_ff, sz_ff);
      t20_ff    <= erm_pkg::mul_q30(cxsy_ff, cz_ff);
      t21_ff    <= erm_pkg::mul_q30(cxsy_ff, sz_ff);
      b_cycz_ff <= cycz_ff;
      b_cysz_ff <= cysz_ff;
      b_sxcy_ff <= sxcy_ff;
      b_cxcy_ff <= cxcy_ff;
      b_sy_ff   <= sy_ff;
      b_cxsz_ff <= cxsz_ff;
      b_cxcz_ff <= cxcz_ff;
      b_sxsz_ff <= sxsz_ff;
      b_sxcz_ff <= sxcz_ff;

      v_ff[0] <= 34'(b_cycz_ff);
      v_ff[1] <= 34'(b_cysz_ff);
      v_ff[2] <= -34'(b_sy_ff);
      v_ff[3] <= 34'(t10_ff) - 34'(b_cxsz_ff);
      v_ff[4] <= 34'(t11_ff) + 34'(b_cxcz_ff);
      v_ff[5] <= 34'(b_sxcy_ff);
      v_ff[6] <= 34'(t20_ff) + 34'(b_sxsz_ff);
      v_ff[7] <= 34'(t21_ff) - 34'(b_sxcz_ff);
      v_ff[8] <= 34'(b_cxcy_ff);

      m_ff <= m_in;
   end

   // round half away from zero to FRAC_BITS, clamp to plus or minus one
   always_comb begin
      logic [33:0] mag;
      logic [33:0] rnd;
      for (int i = 0; i < 9; i++) begin
         mag = v_ff[i][33] ? 34'(-v_ff[i]) : 34'(v_ff[i]);
         rnd = (mag + RND) >> SH;
         if (rnd > SAT) begin
            rnd = SAT;
         end
         m_in[i] = v_ff[i][33] ? OUT_W'(-rnd) : OUT_W'(rnd);
      end
   end

   erm_queue #(
      .WIDTH (9 * OUT_W),
      .DEPTH (erm_pkg::OUTQ_DEPTH)
   ) u_outq (
      .clock (clock),
      .reset (reset),
      .push  (oq_push),
      .wdata (m_ff),
      .full  (oq_full),
      .pop   (rsp_pop),
      .rdata (rsp_m),
      .empty (rsp_empty),
      .count (oq_count)
   );

   // credit check keeps the queue from overflowing; full only bounds the count
   logic unused_full;
   assign unused_full = oq_full;
endmodule

@@ tb/tb_euler_rotation_matrix.sv @@
// Testbench for euler_rotation_matrix: directed and random angle triples, bit-exact matrix check.
// Depends on erm_pkg and the euler_rotation_matrix RTL.
`timescale 1ns / 1ps

module tb_euler_rotation_matrix;

   localparam int ABITS = erm_pkg::ANGLE_BITS_DEF;
   localparam int FBITS = erm_pkg::FRAC_BITS_DEF;
   localparam int OBITS = FBITS + 2;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 2 * erm_pkg::BK_LAT + 10;

   typedef struct {
      logic [OBITS-1:0] m [9];
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [ABITS-1:0] req_angle_x = '0;
   logic [ABITS-1:0] req_angle_y = '0;
   logic [ABITS-1:0] req_angle_z = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [OBITS-1:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [OBITS-1:0] rsp_m20, rsp_m21, rsp_m22;

   matrix_type pending_matrices [$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   euler_rotation_matrix dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_angle_x(req_angle_x), .req_angle_y(req_angle_y), .req_angle_z(req_angle_z),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_m00(rsp_m00), .rsp_m01(rsp_m01), .rsp_m02(rsp_m02),
      .rsp_m10(rsp_m10), .rsp_m11(rsp_m11), .rsp_m12(rsp_m12),
      .rsp_m20(rsp_m20), .rsp_m21(rsp_m21), .rsp_m22(rsp_m22)
   );

   // Taylor series in Horner form; lane selects sine or cosine divisors
   function automatic longint unsigned horner(input longint unsigned x2, input bit sine_lane);
      longint unsigned p;
      longint unsigned dv [6];
      p = 64'd1 << 30;
      if (sine_lane) dv = '{156, 110, 72, 42, 20, 6};
      else dv = '{132, 90, 56, 30, 12, 2};
      for (int i = 0; i < 6; i++)
         p = (64'd1 << 30) - (((x2 * p) >> 30) / dv[i]);
      return p;
   endfunction

   function automatic void angle_sincos(input logic [ABITS-1:0] a, output longint sn,
                                        output longint cs);
      longint unsigned t, r, x, x2;
      longint s, c;
      logic [2:0] oct;
      t = longint'(a) << (32 - ABITS);
      oct = t[31:29];
      r = t & ((64'd1 << 29) - 1);
      if (oct[0]) r = (64'd1 << 29) - r;
      x = (r * 64'd843314857 + (64'd1 << 28)) >> 29;
      x2 = (x * x) >> 30;
      s = longint'((x * horner(x2, 1'b1)) >> 30);
      c = longint'(horner(x2, 1'b0));
      case (oct)
         3'd0: begin sn = s;  cs = c;  end
         3'd1: begin sn = c;  cs = s;  end
         3'd2: begin sn = c;  cs = -s; end
         3'd3: begin sn = s;  cs = -c; end
         3'd4: begin sn = -s; cs = -c; end
         3'd5: begin sn = -c; cs = -s; end
         3'd6: begin sn = -c; cs = s;  end
         default: begin sn = -s; cs = c; end
      endcase
   endfunction

   function automatic longint q30_product(input longint a, input longint b);
      longint unsigned ua, ub, p;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = (ua * ub + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   // Round Q1.30 to the output format and clamp to plus or minus one
   function automatic logic [OBITS-1:0] to_entry(input longint v);
      longint unsigned m;
      longint r;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (30 - FBITS - 1))) >> (30 - FBITS);
      if (m > (64'd1 << FBITS)) m = 64'd1 << FBITS;
      r = (v < 0) ? -longint'(m) : longint'(m);
      return r[OBITS-1:0];
   endfunction

   function automatic matrix_type rotation_matrix(input logic [ABITS-1:0] ax,
                                                  input logic [ABITS-1:0] ay,
                                                  input logic [ABITS-1:0] az);
      longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
      matrix_type mt;
      angle_sincos(ax, sx, cx);
      angle_sincos(ay, sy, cy);
      angle_sincos(az, sz, cz);
      sxsy = q30_product(sx, sy);
      cxsy = q30_product(cx, sy);
      mt.m[0] = to_entry(q30_product(cy, cz));
      mt.m[1] = to_entry(q30_product(cy, sz));
      mt.m[2] = to_entry(-sy);
      mt.m[3] = to_entry(q30_product(sxsy, cz) - q30_product(cx, sz));
      mt.m[4] = to_entry(q30_product(sxsy, sz) + q30_product(cx, cz));
      mt.m[5] = to_entry(q30_product(sx, cy));
      mt.m[6] = to_entry(q30_product(cxsy, cz) + q30_product(sx, sz));
      mt.m[7] = to_entry(q30_product(cxsy, sz) - q30_product(sx, cz));
      mt.m[8] = to_entry(q30_product(cx, cy));
      return mt;
   endfunction

   // Push one word, wait for acceptance, then maybe end the burst with a gap
   task automatic send_angles(input logic [ABITS-1:0] ax, input logic [ABITS-1:0] ay,
                              input logic [ABITS-1:0] az);
      req_push <= 1'b1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      @(posedge clock);
      while (req_full) @(posedge clock);
      pending_matrices.insert(pending_matrices.size(), rotation_matrix(ax, ay, az));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
      end
   endtask

   // One pick in four is a multiple of an octant or within two of one, else uniform
   function automatic logic [ABITS-1:0] pick_angle();
      logic [ABITS-1:0] a;
      case ($urandom_range(0, 3))
         0: begin
            a = ABITS'($urandom_range(0, 7)) << (ABITS - 3);
            a = a + ABITS'($urandom_range(0, 4)) - ABITS'(2);
         end
         default: a = ABITS'($urandom);
      endcase
      return a;
   endfunction

   task automatic test_directed();
      logic [ABITS-1:0] corners [10];
      corners = '{16'h0000, 16'hFFFF, 16'h2000, 16'h1FFF, 16'h2001,
                  16'h4000, 16'h8000, 16'hC000, 16'h6000, 16'hA000};
      for (int i = 0; i < 10; i++) send_angles(corners[i], 16'h0000, 16'h0000);
      for (int i = 0; i < 6; i++) send_angles(16'h0000, corners[i], corners[9 - i]);
      send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_angles(16'h5555, 16'hAAAA, 16'h5555);
      send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
      send_angles(16'h4000, 16'h4000, 16'h4000);
      send_angles(16'hC000, 16'h2000, 16'hE000);
      send_angles(16'h1234, 16'hFEDC, 16'h8001);
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_angles(pick_angle(), pick_angle(), pick_angle());
   endtask

   // Receiver: stall pattern changes mode every so often, including no stalls
   always @(posedge clock) begin
      if ($urandom_range(0, 40) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= ($urandom_range(0, 1) == 0);
         2: rsp_pop <= ($urandom_range(0, 7) == 0);
         default: rsp_pop <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      logic signed [OBITS-1:0] seen [9];
      matrix_type want;
      seen = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
               rsp_m20, rsp_m21, rsp_m22};
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_matrices.size() == 0) begin
            $display("%0t: unexpected word, m00=%0d", $time, seen[0]);
            errors++;
         end else begin
            want = pending_matrices.pop_front();
            for (int i = 0; i < 9; i++)
               if (seen[i] !== want.m[i]) begin
                  $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                           $signed(want.m[i]), seen[i]);
                  errors++;
               end
         end
      end
   end

   // Watchdog: count cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(650);
      req_push <= 1'b0;
      while (pending_matrices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
